>>> design/jmv_pkg.sv
// Package: phase codes, literal tables and result types for the manifest checker.
package jmv_pkg;

  localparam int unsigned LIT_MAX = 18;

  typedef enum logic [3:0] {
    PH_LIT0        = 4'd0,
    PH_FORMAT_NUM  = 4'd1,
    PH_LIT1        = 4'd2,
    PH_COUNTER_NUM = 4'd3,
    PH_LIT2        = 4'd4,
    PH_SHA_STR     = 4'd5,
    PH_LIT3        = 4'd6,
    PH_SIZE_NUM    = 4'd7,
    PH_LIT4        = 4'd8,
    PH_TARGET_STR  = 4'd9,
    PH_LIT5        = 4'd10,
    PH_VERSION_STR = 4'd11,
    PH_LIT6        = 4'd12,
    PH_END         = 4'd13,
    PH_SPARE14     = 4'd14,
    PH_SPARE15     = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    TAG_STRUCT  = 2'd0,
    TAG_DIGEST  = 2'd1,
    TAG_VERSION = 2'd2,
    TAG_UNUSED  = 2'd3
  } tag_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW    = 8'h20;
  localparam logic [7:0] CH_HIGH   = 8'h7e;
  localparam logic [6:0] SHA_CHARS = 7'd64;
  localparam logic [6:0] TGT_CHARS = 7'd7;

  typedef struct packed {
    logic [1:0]  field_tag;
    logic [7:0]  field_value;
    logic [5:0]  field_position;
    logic        finished;
    logic        manifest_valid;
    logic [31:0] rel_count;
    logic [31:0] image_size;
  } result_t;

  function automatic logic [4:0] lit_len(input logic [2:0] which);
    unique case (which)
      3'd0: lit_len = 5'd10;
      3'd1: lit_len = 5'd18;
      3'd2: lit_len = 5'd10;
      3'd3: lit_len = 5'd8;
      3'd4: lit_len = 5'd10;
      3'd5: lit_len = 5'd11;
      3'd6: lit_len = 5'd1;
      default: lit_len = 5'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [2:0] which, input logic [4:0] idx);
    string s;
    s = "";
    unique case (which)
      3'd0: s = "{\"format\":";
      3'd1: s = ",\"releaseCounter\":";
      3'd2: s = ",\"sha256\":";
      3'd3: s = ",\"size\":";
      3'd4: s = ",\"target\":";
      3'd5: s = ",\"version\":";
      3'd6: s = "}";
      default: s = "";
    endcase
    if (int'(idx) < s.len()) lit_char = s[idx];
    else lit_char = 8'h00;
  endfunction

  function automatic logic [7:0] target_char(input logic [2:0] idx);
    unique case (idx)
      3'd0: target_char = "e";
      3'd1: target_char = "s";
      3'd2: target_char = "p";
      3'd3: target_char = "3";
      3'd4: target_char = "2";
      3'd5: target_char = "c";
      3'd6: target_char = "3";
      default: target_char = 8'h00;
    endcase
  endfunction

endpackage

>>> design/jmv_stream_if.sv
// Interfaces: valid/ready channels for manifest bytes and result items.
interface jmv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] manifest_byte;
  logic       last_byte;
  modport source (output valid, manifest_byte, last_byte, input ready);
  modport sink (input valid, manifest_byte, last_byte, output ready);
endinterface

interface jmv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  field_tag;
  logic [7:0]  field_value;
  logic [5:0]  field_position;
  logic        finished;
  logic        manifest_valid;
  logic [31:0] rel_count;
  logic [31:0] image_size;
  modport source (output valid, field_tag, field_value, field_position, finished,
                  manifest_valid, rel_count, image_size, input ready);
  modport sink (input valid, field_tag, field_value, field_position, finished,
                manifest_valid, rel_count, image_size, output ready);
endinterface

>>> design/jmv_parser.sv
// Parser: per-byte state update and result computation for the manifest checker.
module jmv_parser
  import jmv_pkg::*;
#(
  parameter int unsigned MAX_MANIFEST_BYTES = 1024,
  parameter int unsigned MAX_VERSION_CHARS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  manifest_byte,
  input  logic        last_byte,
  input  logic [31:0] max_image_bytes,
  output result_t     result
);

  localparam int unsigned CW = $clog2(MAX_MANIFEST_BYTES + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MANIFEST_BYTES);
  localparam logic [6:0] VER_MAX = 7'(MAX_VERSION_CHARS);

  phase_t      phase, phase_next;
  logic [4:0]  lit_idx, lit_idx_next;
  logic [32:0] acc, acc_next;
  logic        started, started_next;
  logic        lzero, lzero_next;
  logic [6:0]  str_len, str_len_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic        err, err_next;
  logic [31:0] held_rc, held_rc_next;
  logic [31:0] held_sz, held_sz_next;

  logic [7:0]  c;
  logic        is_dig, is_hex_af, ver_ok, printable;
  logic [3:0]  dig, hexv;
  logic [35:0] acc_mul;
  logic [2:0]  which;
  logic [4:0]  ll;
  logic        lit_ok, do_lit;
  logic [1:0]  tag;
  logic [7:0]  val;
  logic [5:0]  pos;

  assign c         = manifest_byte;
  assign is_dig    = (c >= "0") && (c <= "9");
  assign is_hex_af = (c >= "a") && (c <= "f");
  assign dig       = 4'(c - "0");
  assign hexv      = is_dig ? dig : 4'(c - "a" + 8'd10);
  assign ver_ok    = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || is_dig ||
                     (c == ".") || (c == "_") || (c == "+") || (c == "-");
  assign printable = (c >= CH_LOW) && (c <= CH_HIGH) && (c != CH_BSLASH);
  // acc*10 = acc*8 + acc*2; acc stays below 2^32 while no error is set
  assign acc_mul   = {acc[32:0], 3'b000} + {2'b00, acc[32:0], 1'b0} + 36'(dig);

  always_comb begin
    phase_next      = phase;
    lit_idx_next    = lit_idx;
    acc_next        = acc;
    started_next    = started;
    lzero_next      = lzero;
    str_len_next    = str_len;
    byte_count_next = byte_count;
    err_next        = err;
    held_rc_next    = held_rc;
    held_sz_next    = held_sz;
    tag             = TAG_STRUCT;
    val             = 8'd0;
    pos             = 6'd0;
    do_lit          = 1'b0;
    which           = 3'd0;
    ll              = 5'd0;
    lit_ok          = 1'b0;

    if (byte_count <= MAX_CNT) byte_count_next = byte_count + 1'b1;
    if (byte_count_next > MAX_CNT) err_next = 1'b1;

    if (!err_next) begin
      if (phase >= PH_END) begin
        err_next = 1'b1;
      end else if (phase == PH_FORMAT_NUM || phase == PH_COUNTER_NUM ||
                   phase == PH_SIZE_NUM) begin
        if (is_dig) begin
          if (started && lzero) begin
            err_next = 1'b1;
          end else begin
            if (!started) lzero_next = (c == "0");
            started_next = 1'b1;
            acc_next = acc_mul[32:0];
            if (acc_mul[35:32] != 4'd0) err_next = 1'b1;
          end
        end else if (!started) begin
          err_next = 1'b1;
        end else begin
          if (phase == PH_FORMAT_NUM) begin
            if (acc != 33'd1) err_next = 1'b1;
          end else begin
            if (acc == 33'd0) err_next = 1'b1;
            if (phase == PH_COUNTER_NUM) held_rc_next = acc[31:0];
            else held_sz_next = acc[31:0];
          end
          acc_next     = 33'd0;
          started_next = 1'b0;
          lzero_next   = 1'b0;
          phase_next   = phase_t'(phase + 4'd1);
          lit_idx_next = 5'd0;
          do_lit       = !err_next;
        end
      end else if (phase == PH_SHA_STR || phase == PH_TARGET_STR ||
                   phase == PH_VERSION_STR) begin
        if (!started) begin
          if (c == CH_QUOTE) begin
            started_next = 1'b1;
            str_len_next = 7'd0;
          end else begin
            err_next = 1'b1;
          end
        end else if (c == CH_QUOTE) begin
          if ((phase == PH_SHA_STR && str_len != SHA_CHARS) ||
              (phase == PH_TARGET_STR && str_len != TGT_CHARS) ||
              (phase == PH_VERSION_STR && (str_len == 7'd0 || str_len > VER_MAX))) begin
            err_next = 1'b1;
          end else begin
            started_next = 1'b0;
            str_len_next = 7'd0;
            lit_idx_next = 5'd0;
            phase_next   = phase_t'(phase + 4'd1);
          end
        end else if (!printable) begin
          err_next = 1'b1;
        end else if (phase == PH_SHA_STR) begin
          if (!(is_dig || is_hex_af) || str_len >= SHA_CHARS) begin
            err_next = 1'b1;
          end else begin
            tag = TAG_DIGEST;
            val = {4'd0, hexv};
            pos = str_len[5:0];
            str_len_next = str_len + 7'd1;
          end
        end else if (phase == PH_TARGET_STR) begin
          if (str_len >= TGT_CHARS || c != target_char(str_len[2:0])) begin
            err_next = 1'b1;
          end else begin
            str_len_next = str_len + 7'd1;
          end
        end else begin
          if (!ver_ok || str_len >= VER_MAX) begin
            err_next = 1'b1;
          end else begin
            tag = TAG_VERSION;
            val = c;
            pos = str_len[5:0];
            str_len_next = str_len + 7'd1;
          end
        end
      end else begin
        do_lit = 1'b1;
      end

      // literal matcher, also takes the byte that ended a number
      if (do_lit) begin
        which  = phase_next[3:1];
        ll     = lit_len(which);
        lit_ok = (lit_idx_next < ll) && (c == lit_char(which, lit_idx_next));
        if (!lit_ok) begin
          err_next = 1'b1;
        end else if (lit_idx_next + 5'd1 == ll) begin
          lit_idx_next = 5'd0;
          phase_next   = phase_t'(phase_next + 4'd1);
        end else begin
          lit_idx_next = lit_idx_next + 5'd1;
        end
      end
    end

    if (err_next) begin
      tag = TAG_STRUCT;
      val = 8'd0;
      pos = 6'd0;
    end

    result.field_tag       = tag;
    result.field_value     = val;
    result.field_position  = pos;
    result.finished        = last_byte;
    result.manifest_valid  = 1'b0;
    result.rel_count       = 32'd0;
    result.image_size      = 32'd0;
    if (last_byte && !err_next && phase_next == PH_END && held_sz_next <= max_image_bytes) begin
      result.manifest_valid  = 1'b1;
      result.rel_count       = held_rc_next;
      result.image_size      = held_sz_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase      <= PH_LIT0;
      lit_idx    <= 5'd0;
      acc        <= 33'd0;
      started    <= 1'b0;
      lzero      <= 1'b0;
      str_len    <= 7'd0;
      byte_count <= '0;
      err        <= 1'b0;
      held_rc    <= 32'd0;
      held_sz    <= 32'd0;
    end else if (step) begin
      phase      <= phase_next;
      lit_idx    <= lit_idx_next;
      acc        <= acc_next;
      started    <= started_next;
      lzero      <= lzero_next;
      str_len    <= str_len_next;
      byte_count <= byte_count_next;
      err        <= err_next;
      held_rc    <= held_rc_next;
      held_sz    <= held_sz_next;
    end
  end

  a_acc_fits: assert property (@(posedge clk) disable iff (rst) !err |-> !acc[32])
    else $error("accumulator over 32 bits without error");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err && !(step && last_byte)) |=> err)
    else $error("error flag cleared mid-manifest");
  a_tag_quiet: assert property (@(posedge clk) disable iff (rst)
    (err || err_next) |-> (result.field_tag == TAG_STRUCT))
    else $error("field reported after error");
  a_valid_end: assert property (@(posedge clk) disable iff (rst)
    result.manifest_valid |-> (result.finished && phase_next == PH_END))
    else $error("valid verdict before the end");

endmodule

>>> design/json_manifest_validator_core.sv
// Top level: byte-stream manifest checker with registered result stage.
// Each accepted byte's result item is registered and shows in the next cycle.
// Throughput: one byte per cycle while the sink takes results; the single parse state update bounds it.
// Output register with ready pass-through keeps a byte flowing each cycle
// while the sink takes results.
// Reset (rst, synchronous) clears the parse state and the result valid flag,
// and sets max_image_bytes to 4194304.
module json_manifest_validator_core
  import jmv_pkg::*;
#(
  parameter int unsigned MAX_MANIFEST_BYTES = 1024,
  parameter int unsigned MAX_VERSION_CHARS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  jmv_in_if.sink      in_ch,
  jmv_out_if.source   out_ch
);

  logic [31:0] max_image;
  logic        step;
  logic        out_valid;
  result_t     res, res_q;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  jmv_parser #(
    .MAX_MANIFEST_BYTES(MAX_MANIFEST_BYTES),
    .MAX_VERSION_CHARS (MAX_VERSION_CHARS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .manifest_byte  (in_ch.manifest_byte),
    .last_byte      (in_ch.last_byte),
    .max_image_bytes(max_image),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_image <= 32'd4194304;
    end else if (cfg_we) begin
      max_image <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_q <= res;
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.field_tag       = res_q.field_tag;
  assign out_ch.field_value     = res_q.field_value;
  assign out_ch.field_position  = res_q.field_position;
  assign out_ch.finished        = res_q.finished;
  assign out_ch.manifest_valid  = res_q.manifest_valid;
  assign out_ch.rel_count       = res_q.rel_count;
  assign out_ch.image_size      = res_q.image_size;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !step)
    else $error("item accepted over a stalled result");
  a_fill: assert property (@(posedge clk) disable iff (rst) step |=> out_valid)
    else $error("accepted item produced no result");
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_q.finished) |-> !res_q.manifest_valid)
    else $error("verdict on an unfinished item");

endmodule
